[src/flow_heavy_hitter_counter_top_assert.svh]
// assertion macros of the flow heavy hitter counter, used by the controller
// no dependencies; included by the files that carry assertions
`ifndef FLOW_HEAVY_HITTER_COUNTER_TOP_ASSERT_SVH
`define FLOW_HEAVY_HITTER_COUNTER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FHHC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fhhc check failed");

// next-cycle implication, disabled while in reset
`define FHHC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fhhc check failed");

`endif

[src/fhhc_pkg.sv]
// shared types and constants of the flow heavy hitter counter
// no dependencies; imported by the controller, datapath and top level
package fhhc_pkg;

    // input command codes
    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_EPOCH = 1'b1;

    // hash constants
    localparam logic [31:0] HASH_SEED = 32'h0000_0001;
    localparam logic [31:0] HASH_C1   = 32'hcc9e_2d51;
    localparam logic [31:0] HASH_C2   = 32'h1b87_3593;
    localparam logic [31:0] HASH_MIX  = 32'he654_6b64;
    localparam logic [31:0] HASH_F1   = 32'h85eb_ca6b;
    localparam logic [31:0] HASH_F2   = 32'hc2b2_ae35;

    localparam logic [31:0] THRESHOLD_RESET = 32'd1000;
    localparam logic [31:0] COUNT_MAX       = 32'hffff_ffff;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_EPOCH,
        OP_LOAD_B0,
        OP_LOAD_B1,
        OP_LOAD_TAIL,
        OP_MUL_C1,
        OP_ROT_C2,
        OP_MIX,
        OP_XOR_TAIL,
        OP_FIN1,
        OP_FIN2,
        OP_FIN3,
        OP_MOD,
        OP_BASE,
        OP_READ,
        OP_CMP,
        OP_UPD,
        OP_INIT_WR,
        OP_EPOCH_WR
    } fhhc_op_t;

    // status back to the controller
    typedef struct packed {
        logic hit;
        logic out_busy;
    } fhhc_sts_t;

endpackage

[src/fhhc_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module fhhc_ram #(
    parameter int WIDTH = 97,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/fhhc_datapath.sv]
// datapath: hash unit, bucket reduction, table memory, update and result register
// depends on fhhc_pkg and fhhc_ram
module fhhc_datapath import fhhc_pkg::*; #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int WAYS          = 8,
    parameter int KEY_BITS      = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fhhc_op_t                           op_i,
    input  logic [$clog2(2*TABLE_ENTRIES)-1:0] cnt_i,
    output fhhc_sts_t                          sts_o,
    input  logic [63:0]                        s_tdata,
    input  logic                               cfg_valid,
    input  logic [31:0]                        cfg_data,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [95:0]                        m_tdata,
    output logic [1:0]                         m_tuser
);

    localparam int DEPTH     = 2 * TABLE_ENTRIES;
    localparam int AW        = $clog2(DEPTH);
    localparam int BUCKETS   = TABLE_ENTRIES / WAYS;
    localparam int RW        = $clog2(BUCKETS) + 2;
    localparam int MW        = 1 + KEY_BITS + 32;
    localparam int KEY_BYTES = (KEY_BITS + 7) / 8;
    localparam logic [31:0] KEY_LEN = 32'(KEY_BYTES);
    localparam int RL        = $clog2(BUCKETS);
    localparam logic [32:0] RECIP =
        33'(((64'd1 << (32 + RL)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    logic [KEY_BITS-1:0] key_reg;
    logic [31:0]         h_reg;
    logic [31:0]         k_reg;
    logic [31:0]         q_reg;
    logic [RW-1:0]       rem_reg;
    logic [AW-1:0]       base_reg;
    logic [AW-1:0]       addr_reg;
    logic [AW-1:0]       slot_reg;
    logic                found_reg;
    logic                free_reg;
    logic [31:0]         old_reg;
    logic                bank_reg;
    logic [31:0]         thr_reg;
    logic                out_valid_reg;
    logic [31:0]         out_count_reg;
    logic                out_hh_reg;
    logic [63:0]         out_key_reg;
    logic                out_full_reg;

    // hash input bytes, most significant key byte first
    logic [63:0] key64;
    logic [7:0]  hb [8];
    assign key64 = 64'(key_reg);

    for (genvar i = 0; i < 8; i++) begin : g_bytes
        if (i < KEY_BYTES) begin : g_on
            assign hb[i] = key64[8*(KEY_BYTES-1-i) +: 8];
        end else begin : g_off
            assign hb[i] = 8'h00;
        end
    end

    logic [31:0] word0, word1, word_tail;
    assign word0     = {hb[3], hb[2], hb[1], hb[0]};
    assign word1     = {hb[7], hb[6], hb[5], hb[4]};
    assign word_tail = {8'h00, hb[6], hb[5], hb[4]};

    // shared multiplier operand selection
    logic [31:0] fin_x, mul_a, mul_b, prod;
    assign fin_x = h_reg ^ KEY_LEN;

    always_comb begin
        case (op_i)
            OP_ROT_C2: begin
                mul_a = {k_reg[16:0], k_reg[31:17]};
                mul_b = HASH_C2;
            end
            OP_FIN1: begin
                mul_a = fin_x ^ (fin_x >> 16);
                mul_b = HASH_F1;
            end
            OP_FIN2: begin
                mul_a = h_reg ^ (h_reg >> 13);
                mul_b = HASH_F2;
            end
            default: begin
                mul_a = k_reg;
                mul_b = HASH_C1;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // block mix: rotate by 13, times 5, plus constant
    logic [31:0] mix_x, mix_r, mix_h;
    assign mix_x = h_reg ^ k_reg;
    assign mix_r = {mix_x[18:0], mix_x[31:19]};
    assign mix_h = (mix_r << 2) + mix_r + HASH_MIX;

    // bucket remainder by reciprocal multiplication: quotient, then remainder
    logic [64:0] q_prod, q_shift;
    logic [31:0] q_times_b, rem_full;
    assign q_prod    = 65'(h_reg) * 65'(RECIP);
    assign q_shift   = q_prod >> (32 + RL);
    assign q_times_b = q_reg * 32'(BUCKETS);
    assign rem_full  = h_reg - q_times_b;

    // table memory: valid, key, count
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, rd_addr;
    logic [MW-1:0] ram_wdata, ram_rdata;
    logic          rd_valid;
    logic [KEY_BITS-1:0] rd_key;
    logic [31:0]   rd_count;
    logic          rd_match;

    assign rd_addr  = base_reg + cnt_i;
    assign ram_re   = (op_i == OP_READ);
    assign rd_valid = ram_rdata[MW-1];
    assign rd_key   = ram_rdata[KEY_BITS+31:32];
    assign rd_count = ram_rdata[31:0];
    assign rd_match = rd_valid && (rd_key == key_reg);

    // saturating increment of the found or new entry
    logic [31:0] old_eff, new_count;
    logic        do_store;
    assign old_eff   = found_reg ? old_reg : 32'd0;
    assign new_count = (old_eff == COUNT_MAX) ? old_eff : old_eff + 32'd1;
    assign do_store  = found_reg || free_reg;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = '0;
        case (op_i)
            OP_UPD: begin
                ram_we    = do_store;
                ram_wdata = {1'b1, key_reg, new_count};
            end
            OP_INIT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_i;
            end
            OP_EPOCH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = (bank_reg ? AW'(0) : AW'(TABLE_ENTRIES)) + cnt_i;
            end
            default: ;
        endcase
    end

    fhhc_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // control registers: bank, threshold, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg      <= 1'b0;
            thr_reg       <= THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
            if (op_i == OP_EPOCH) begin
                bank_reg <= ~bank_reg;
            end
            if (op_i == OP_EPOCH || op_i == OP_UPD) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hash, lookup and result payload
    always_ff @(posedge aclk) begin
        case (op_i)
            OP_ACCEPT: begin
                key_reg   <= s_tdata[KEY_BITS-1:0];
                h_reg     <= HASH_SEED;
                rem_reg   <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            OP_LOAD_B0:   k_reg <= word0;
            OP_LOAD_B1:   k_reg <= word1;
            OP_LOAD_TAIL: k_reg <= word_tail;
            OP_MUL_C1:    k_reg <= prod;
            OP_ROT_C2:    k_reg <= prod;
            OP_MIX:       h_reg <= mix_h;
            OP_XOR_TAIL:  h_reg <= h_reg ^ k_reg;
            OP_FIN1:      h_reg <= prod;
            OP_FIN2:      h_reg <= prod;
            OP_FIN3:      h_reg <= h_reg ^ (h_reg >> 16);
            OP_MOD: begin
                if (!cnt_i[0]) begin
                    q_reg <= q_shift[31:0];
                end else begin
                    rem_reg <= rem_full[RW-1:0];
                end
            end
            OP_BASE: begin
                base_reg <= (bank_reg ? AW'(TABLE_ENTRIES) : AW'(0)) + AW'(rem_reg * WAYS);
            end
            OP_READ: addr_reg <= rd_addr;
            OP_CMP: begin
                if (rd_match) begin
                    found_reg <= 1'b1;
                    slot_reg  <= addr_reg;
                    old_reg   <= rd_count;
                end else if (!rd_valid && !free_reg) begin
                    free_reg <= 1'b1;
                    slot_reg <= addr_reg;
                end
            end
            OP_UPD: begin
                if (do_store) begin
                    out_count_reg <= new_count;
                    out_hh_reg    <= (new_count != old_eff) && (new_count == thr_reg);
                    out_key_reg   <= ((new_count != old_eff) && (new_count == thr_reg)) ?
                                     64'(key_reg) : 64'd0;
                    out_full_reg  <= 1'b0;
                end else begin
                    out_count_reg <= 32'd0;
                    out_hh_reg    <= 1'b0;
                    out_key_reg   <= 64'd0;
                    out_full_reg  <= 1'b1;
                end
            end
            OP_EPOCH: begin
                out_count_reg <= 32'd0;
                out_hh_reg    <= 1'b0;
                out_key_reg   <= 64'd0;
                out_full_reg  <= 1'b0;
            end
            default: ;
        endcase
    end

    assign sts_o.hit      = rd_match;
    assign sts_o.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_key_reg, out_count_reg};
    assign m_tuser  = {out_full_reg, out_hh_reg};

endmodule

[src/fhhc_ctrl.sv]
// controller: sequences hashing, bucket search, update, epoch and clearing sweeps
// depends on fhhc_pkg and the assertion macro header
`include "flow_heavy_hitter_counter_top_assert.svh"

module fhhc_ctrl import fhhc_pkg::*; #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int WAYS          = 8,
    parameter int KEY_BITS      = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_cmd,
    output logic                               s_tready,
    input  fhhc_sts_t                          sts_i,
    output fhhc_op_t                           op_o,
    output logic [$clog2(2*TABLE_ENTRIES)-1:0] cnt_o
);

    localparam int AW        = $clog2(2 * TABLE_ENTRIES);
    localparam int KEY_BYTES = (KEY_BITS + 7) / 8;
    localparam int NBLK      = KEY_BYTES / 4;
    localparam int TAILN     = KEY_BYTES % 4;

    typedef enum logic [19:0] {
        S_INIT = 20'h00001,
        S_IDLE = 20'h00002,
        S_B0   = 20'h00004,
        S_C1   = 20'h00008,
        S_C2   = 20'h00010,
        S_MIX  = 20'h00020,
        S_TL   = 20'h00040,
        S_TC1  = 20'h00080,
        S_TC2  = 20'h00100,
        S_TX   = 20'h00200,
        S_F1   = 20'h00400,
        S_F2   = 20'h00800,
        S_F3   = 20'h01000,
        S_MOD  = 20'h02000,
        S_BASE = 20'h04000,
        S_RD   = 20'h08000,
        S_CMP  = 20'h10000,
        S_UPD  = 20'h20000,
        S_CLR  = 20'h40000,
        S_OUT  = 20'h80000
    } fhhc_state_t;

    fhhc_state_t   state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          blk_reg, blk_next;

    // next state and operation
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        blk_next   = blk_reg;
        op_o       = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                op_o = OP_INIT_WR;
                if (cnt_reg == AW'(2*TABLE_ENTRIES-1)) begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cnt_next = '0;
                    blk_next = 1'b0;
                    if (s_cmd == CMD_EPOCH) begin
                        op_o       = OP_EPOCH;
                        state_next = S_CLR;
                    end else begin
                        op_o       = OP_ACCEPT;
                        state_next = S_B0;
                    end
                end
            end
            S_B0: begin
                op_o       = blk_reg ? OP_LOAD_B1 : OP_LOAD_B0;
                state_next = S_C1;
            end
            S_C1: begin
                op_o       = OP_MUL_C1;
                state_next = S_C2;
            end
            S_C2: begin
                op_o       = OP_ROT_C2;
                state_next = S_MIX;
            end
            S_MIX: begin
                op_o = OP_MIX;
                if (blk_reg == 1'(NBLK-1)) begin
                    state_next = (TAILN != 0) ? S_TL : S_F1;
                end else begin
                    blk_next   = 1'b1;
                    state_next = S_B0;
                end
            end
            S_TL: begin
                op_o       = OP_LOAD_TAIL;
                state_next = S_TC1;
            end
            S_TC1: begin
                op_o       = OP_MUL_C1;
                state_next = S_TC2;
            end
            S_TC2: begin
                op_o       = OP_ROT_C2;
                state_next = S_TX;
            end
            S_TX: begin
                op_o       = OP_XOR_TAIL;
                state_next = S_F1;
            end
            S_F1: begin
                op_o       = OP_FIN1;
                state_next = S_F2;
            end
            S_F2: begin
                op_o       = OP_FIN2;
                state_next = S_F3;
            end
            S_F3: begin
                op_o       = OP_FIN3;
                cnt_next   = '0;
                state_next = S_MOD;
            end
            // bucket quotient, then remainder
            S_MOD: begin
                op_o = OP_MOD;
                if (cnt_reg[0]) begin
                    cnt_next   = '0;
                    state_next = S_BASE;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_BASE: begin
                op_o       = OP_BASE;
                state_next = S_RD;
            end
            S_RD: begin
                op_o       = OP_READ;
                state_next = S_CMP;
            end
            S_CMP: begin
                op_o = OP_CMP;
                if (sts_i.hit || cnt_reg == AW'(WAYS-1)) begin
                    state_next = S_UPD;
                end else begin
                    cnt_next   = cnt_reg + AW'(1);
                    state_next = S_RD;
                end
            end
            S_UPD: begin
                op_o       = OP_UPD;
                state_next = S_OUT;
            end
            S_CLR: begin
                op_o = OP_EPOCH_WR;
                if (cnt_reg == AW'(TABLE_ENTRIES-1)) begin
                    cnt_next   = '0;
                    state_next = S_OUT;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_OUT: begin
                if (!sts_i.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            blk_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            blk_reg   <= blk_next;
        end
    end

    assign cnt_o = cnt_reg;

    // memory writes only from update or clearing states
    `FHHC_ASSERT_IMP(a_write_state, aclk, aresetn,
        (op_o == OP_UPD || op_o == OP_INIT_WR || op_o == OP_EPOCH_WR),
        (state_reg == S_UPD || state_reg == S_INIT || state_reg == S_CLR))
    // a matching way ends the bucket search
    `FHHC_ASSERT_NXT(a_hit_update, aclk, aresetn,
        (state_reg == S_CMP && sts_i.hit), (state_reg == S_UPD))
    // an epoch transfer starts the clearing sweep
    `FHHC_ASSERT_NXT(a_epoch_clear, aclk, aresetn,
        (s_tvalid && s_tready && s_cmd == CMD_EPOCH), (state_reg == S_CLR && cnt_reg == '0))

endmodule

[src/flow_heavy_hitter_counter_top.sv]
// A packet is hashed per block (load, multiply, rotate-multiply, mix), then tail and finalisation;
// bucket quotient, remainder and base follow, a read and compare per way searched, an update.
// Throughput: one item at a time, set by the hash sequencer; the next waits until the result is taken.
// An epoch command clears the old bank one entry a cycle.
// Reset: synchronous, active low; afterwards both banks are cleared
// before the first transfer is accepted.
module flow_heavy_hitter_counter_top import fhhc_pkg::*; #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int WAYS          = 8,
    parameter int KEY_BITS      = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // flow_key
    input  logic [0:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // flow_count, hitter_key
    output logic [1:0]  m_tuser,   // heavy_hitter, table_full
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // hitter_threshold
);

    localparam int AW = $clog2(2 * TABLE_ENTRIES);

    fhhc_op_t      op;
    fhhc_sts_t     sts;
    logic [AW-1:0] cnt;

    // threshold writes are always taken
    assign cfg_ready = 1'b1;

    fhhc_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WAYS          (WAYS),
        .KEY_BITS      (KEY_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser[0]),
        .s_tready (s_tready),
        .sts_i    (sts),
        .op_o     (op),
        .cnt_o    (cnt)
    );

    fhhc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WAYS          (WAYS),
        .KEY_BITS      (KEY_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_i      (op),
        .cnt_i     (cnt),
        .sts_o     (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
